### rtl/lsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LRU stack-distance miss counter.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 11;
  localparam int CNT_W    = 32;
  localparam int SIDX_W   = 2;
  localparam int NUM_REGS = 4;
  localparam int REGSEL_W = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef enum logic [REGSEL_W-1:0] {
    REG_CACHE_SIZE_0 = 2'd0,
    REG_CACHE_SIZE_1 = 2'd1,
    REG_CACHE_SIZE_2 = 2'd2,
    REG_CACHE_SIZE_3 = 2'd3
  } reg_sel_t;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  // item travelling down the cell chain
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] c_addr;   // entry being pushed down
    logic              c_valid;
    logic              found;
  } lsd_tok_t;

endpackage

### rtl/lsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_cell
// One LRU stack entry plus the item register that follows it in the chain.
// ----------------------------------------------------------------------------
module lsd_cell #(
  parameter int IDX_W = 10,
  parameter int IDX   = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  lsd_pkg::lsd_tok_t      tok_in,
  input  logic [IDX_W-1:0]       pos_in,
  output lsd_pkg::lsd_tok_t      tok_out,
  output logic [IDX_W-1:0]       pos_out
);
  import lsd_pkg::*;

  logic [ADDR_W-1:0] addr;
  logic              valid;
  logic              active;
  logic              match;
  lsd_tok_t          tok_next;
  logic [IDX_W-1:0]  pos_next;

  assign active = en && tok_in.valid && (tok_in.op == OP_ACCESS) && !tok_in.found;
  assign match  = valid && (addr == tok_in.addr);

  // entry takes the one pushed down from above, also when it was the hit
  always_ff @(posedge clk) begin
    if (active) begin
      addr <= tok_in.c_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (active) begin
      valid <= tok_in.c_valid;
    end
  end

  always_comb begin
    tok_next = tok_in;
    pos_next = pos_in;
    if (active) begin
      tok_next.found   = match;
      tok_next.c_addr  = addr;
      tok_next.c_valid = valid;
      if (match) begin
        pos_next = IDX_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_out <= pos_next;
    end
  end

endmodule

### rtl/lsd_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_report
// Miss counters at the chain exit and the report output register.
// ----------------------------------------------------------------------------
module lsd_report #(
  parameter int IDX_W     = 10,
  parameter int NUM_SIZES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lsd_pkg::lsd_tok_t           tok,
  input  logic [IDX_W-1:0]            pos,
  input  logic [lsd_pkg::SIZE_W-1:0]  sizes [NUM_SIZES],
  output logic                        stall,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lsd_pkg::CNT_W-1:0]   m_tdata,
  output logic [lsd_pkg::SIDX_W-1:0]  m_tuser,
  output logic                        m_tlast
);
  import lsd_pkg::*;

  localparam int CMP_W = ((IDX_W + 1) > SIZE_W) ? (IDX_W + 1) : SIZE_W;
  localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(NUM_SIZES - 1);

  logic [CNT_W-1:0]  counters [NUM_SIZES];
  logic [CNT_W-1:0]  snap     [NUM_SIZES];
  logic              rep_active;
  logic [SIDX_W-1:0] rep_idx;
  logic              en;
  logic              load;
  logic [CMP_W-1:0]  depth;
  logic              miss [NUM_SIZES];

  assign stall = tok.valid && (tok.op == OP_REPORT) && rep_active;
  assign en    = !stall;
  assign load  = rep_active && (!m_tvalid || m_tready);
  assign depth = CMP_W'(pos) + CMP_W'(1);

  always_comb begin
    for (int k = 0; k < NUM_SIZES; k++) begin
      miss[k] = !tok.found || (depth > CMP_W'(sizes[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SIZES; k++) begin
        counters[k] <= '0;
      end
    end else if (en && tok.valid) begin
      for (int k = 0; k < NUM_SIZES; k++) begin
        if (tok.op == OP_REPORT) begin
          counters[k] <= '0;
        end else if (miss[k] && (counters[k] != '1)) begin
          counters[k] <= counters[k] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok.valid && (tok.op == OP_REPORT)) begin
      for (int k = 0; k < NUM_SIZES; k++) begin
        snap[k] <= counters[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_active <= 1'b0;
      rep_idx    <= '0;
    end else if (en && tok.valid && (tok.op == OP_REPORT)) begin
      rep_active <= 1'b1;
      rep_idx    <= '0;
    end else if (load) begin
      if (rep_idx == LAST_IDX) begin
        rep_active <= 1'b0;
      end
      rep_idx <= rep_idx + SIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= snap[rep_idx];
      m_tuser <= rep_idx;
      m_tlast <= (rep_idx == LAST_IDX);
    end
  end

endmodule

### rtl/lru_stack_distance_miss_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_stack_distance_miss_counter
// LRU stack-distance miss counter for up to four fully associative cache sizes.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser = op (0 access, 1 report), tdata = block address.
// Output stream m_*: tdata = miss count, tuser = size index, tlast on the last
// count of a report. APB port writes/reads the four capacity registers at
// 0x0, 0x4, 0x8, 0xC.
// Each item walks down a chain of STACK_DEPTH cells, one cell per cycle unless
// the chain is stalled; each cell compares its entry with the address and
// pushes its entry down until the hit. Items enter one per cycle while s_tready
// is high, so the chain holds up to STACK_DEPTH in flight. Counters update when
// an item leaves the chain. A report's counts pass the report state and the
// output register, NUM_SIZES in all, one per cycle while m_tready is high.
// A report reaching the exit while the previous report is still being sent
// stops the chain and s_tready drops until that report's last count is loaded;
// a stalled receiver holds the output register and so, in time, the chain.
// Reset holds s_tready low, empties the stack, clears counters and sets sizes
// to 1, 2, 4 and 8.
// ----------------------------------------------------------------------------
module lru_stack_distance_miss_counter #(
  parameter int STACK_DEPTH = 1024,
  parameter int NUM_SIZES   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lsd_pkg::ADDR_W-1:0]   s_tdata,   // [31:0] addr
  input  logic                         s_tuser,   // [0] op
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lsd_pkg::CNT_W-1:0]    m_tdata,   // [31:0] miss_count
  output logic [lsd_pkg::SIDX_W-1:0]   m_tuser,   // [1:0] size_index
  output logic                         m_tlast,   // last
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [lsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [lsd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import lsd_pkg::*;

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [SIZE_W-1:0] capacity [NUM_REGS];
  logic [SIZE_W-1:0] sizes    [NUM_SIZES];
  reg_sel_t          reg_sel;
  logic              stall;
  logic              en;
  lsd_tok_t          tok [STACK_DEPTH+1];
  logic [IDX_W-1:0]  pos [STACK_DEPTH+1];

  // configuration
  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[3:2]);
  assign prdata  = PDATA_W'(capacity[reg_sel]);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity[REG_CACHE_SIZE_0] <= SIZE_W'(1);
      capacity[REG_CACHE_SIZE_1] <= SIZE_W'(2);
      capacity[REG_CACHE_SIZE_2] <= SIZE_W'(4);
      capacity[REG_CACHE_SIZE_3] <= SIZE_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CACHE_SIZE_0: capacity[REG_CACHE_SIZE_0] <= pwdata[SIZE_W-1:0];
        REG_CACHE_SIZE_1: capacity[REG_CACHE_SIZE_1] <= pwdata[SIZE_W-1:0];
        REG_CACHE_SIZE_2: capacity[REG_CACHE_SIZE_2] <= pwdata[SIZE_W-1:0];
        REG_CACHE_SIZE_3: capacity[REG_CACHE_SIZE_3] <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_SIZES; k++) begin : g_size
    assign sizes[k] = capacity[k];
  end

  // chain entry
  assign en       = !stall;
  assign s_tready = en && !rst;

  always_comb begin
    tok[0].valid   = s_tvalid && s_tready;
    tok[0].op      = op_t'(s_tuser);
    tok[0].addr    = s_tdata;
    tok[0].c_addr  = s_tdata;
    tok[0].c_valid = 1'b1;
    tok[0].found   = 1'b0;
  end
  assign pos[0] = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    lsd_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (tok[i]),
      .pos_in  (pos[i]),
      .tok_out (tok[i+1]),
      .pos_out (pos[i+1])
    );
  end

  lsd_report #(
    .IDX_W     (IDX_W),
    .NUM_SIZES (NUM_SIZES)
  ) u_report (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok[STACK_DEPTH]),
    .pos      (pos[STACK_DEPTH]),
    .sizes    (sizes),
    .stall    (stall),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
